FILE: hdl/rdpd_pkg.sv
// shared types and constants of the relative depth peak detector
package rdpd_pkg;

   localparam int FRAC_WIDTH = 17;
   localparam int FRAC_SHIFT = 16;
   localparam logic [FRAC_WIDTH-1:0] DEPTH_FRACTION_RESET = FRAC_WIDTH'(49152);

   // results of the two threshold compares for one sample
   typedef struct packed {
      logic rise_ok;
      logic fall_ok;
   } cmp_type;

endpackage

FILE: hdl/relative_depth_peak_detector.sv
// Relative depth peak detector: takes one signed sample per transfer and reports the
// zero-based index of each confirmed local maximum of a record; a sample with
// start_of_record set begins a new record. A sample is taken in every cycle unless a
// peak result waits in the output register under rsp_stall; this rate of one sample
// per cycle is set by the single tracking stage whose state feeds back into the next
// sample's compares (one fraction multiply per threshold). Results pass the sample
// stage and output registers. The user must write the depth fraction register (1/65536
// units, reset 49152) only while no sample is in flight; the block has no check.
module relative_depth_peak_detector import rdpd_pkg::*; #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int INDEX_WIDTH  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                          req_start_of_record,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic        [INDEX_WIDTH-1:0] rsp_peak_index,
   input  logic                          csr_write_enable,
   input  logic        [FRAC_WIDTH-1:0]  csr_write_data
);

   logic                           s1_valid_ff,  s1_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] s1_sample_ff;
   logic                           s1_start_ff;
   logic        [FRAC_WIDTH-1:0]   frac_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic        [INDEX_WIDTH-1:0]  rsp_index_ff;

   logic                           proceed;
   logic                           emit;
   logic        [INDEX_WIDTH-1:0]  peak_index;

   // the sample stage moves on unless a result is stuck in the output register
   assign proceed     = s1_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall   = s1_valid_ff && !proceed;
   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;

   always_comb begin
      if (proceed) begin
         rsp_valid_in = emit;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   rdpd_tracker #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_tracker (
      .clock          (clock),
      .reset          (reset),
      .valid          (proceed),
      .sample         (s1_sample_ff),
      .start_of_record(s1_start_ff),
      .depth_fraction (frac_ff),
      .emit           (emit),
      .peak_index     (peak_index)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         frac_ff      <= DEPTH_FRACTION_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            frac_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_sample_ff <= req_sample;
         s1_start_ff  <= req_start_of_record;
      end
      if (proceed && emit) begin
         rsp_index_ff <= peak_index;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_peak_index = rsp_index_ff;

endmodule

FILE: hdl/rdpd_compare.sv
// exact fixed-point threshold compares against the running minimum and candidate
module rdpd_compare import rdpd_pkg::*; #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic signed [SAMPLE_WIDTH-1:0] running_minimum,
   input  logic signed [SAMPLE_WIDTH-1:0] candidate_maximum,
   input  logic        [FRAC_WIDTH-1:0]   depth_fraction,
   output cmp_type                        cmp
);

   localparam int PW = SAMPLE_WIDTH + FRAC_WIDTH + 1;

   logic signed [PW-1:0] sample_ext;
   logic signed [PW-1:0] minimum_ext;
   logic signed [PW-1:0] maximum_ext;
   logic signed [PW-1:0] frac_ext;
   logic signed [PW-1:0] sample_scaled;
   logic signed [PW-1:0] maximum_scaled;
   logic signed [PW-1:0] minimum_shifted;
   logic signed [PW-1:0] sample_shifted;

   assign sample_ext  = PW'(sample);
   assign minimum_ext = PW'(running_minimum);
   assign maximum_ext = PW'(candidate_maximum);
   assign frac_ext    = $signed(PW'(depth_fraction));

   // products fit in PW bits, no overflow
   assign sample_scaled   = sample_ext * frac_ext;
   assign maximum_scaled  = maximum_ext * frac_ext;
   assign minimum_shifted = minimum_ext <<< FRAC_SHIFT;
   assign sample_shifted  = sample_ext <<< FRAC_SHIFT;

   assign cmp.rise_ok = sample_scaled >= minimum_shifted;
   assign cmp.fall_ok = sample_shifted <= maximum_scaled;

endmodule

FILE: hdl/rdpd_tracker.sv
// direction, candidate and minimum tracking for one sample per cycle while valid is set
module rdpd_tracker import rdpd_pkg::*; #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int INDEX_WIDTH  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          valid,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic                          start_of_record,
   input  logic        [FRAC_WIDTH-1:0]  depth_fraction,
   output logic                          emit,
   output logic        [INDEX_WIDTH-1:0] peak_index
);

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_RUN
   } phase_type;

   phase_type                     phase_ff,   phase_in;
   logic signed [SAMPLE_WIDTH-1:0] prev_ff,    prev_in;
   logic signed [SAMPLE_WIDTH-1:0] min_ff,     min_in;
   logic signed [SAMPLE_WIDTH-1:0] max_ff,     max_in;
   logic        [INDEX_WIDTH-1:0]  idx_ff,     idx_in;
   logic        [INDEX_WIDTH-1:0]  cnt_ff,     cnt_in;
   logic                           held_ff,    held_in;
   logic                           rising_ff,  rising_in;

   logic                           rising_cur;
   logic        [INDEX_WIDTH-1:0]  cnt_next;
   cmp_type                        cmp;

   rdpd_compare #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_compare (
      .sample           (sample),
      .running_minimum  (min_ff),
      .candidate_maximum(max_ff),
      .depth_fraction   (depth_fraction),
      .cmp              (cmp)
   );

   // index saturates at all ones
   assign cnt_next   = (cnt_ff == '1) ? cnt_ff : cnt_ff + INDEX_WIDTH'(1);
   assign rising_cur = (phase_ff == PH_SECOND) ? (sample > prev_ff) : rising_ff;
   assign peak_index = idx_ff;

   always_comb begin
      phase_in  = phase_ff;
      prev_in   = prev_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      held_in   = held_ff;
      rising_in = rising_ff;
      emit      = 1'b0;
      if (valid) begin
         if (start_of_record || phase_ff == PH_FIRST) begin
            prev_in   = sample;
            min_in    = sample;
            max_in    = sample;
            idx_in    = '0;
            cnt_in    = '0;
            held_in   = 1'b1;
            rising_in = 1'b0;
            phase_in  = PH_SECOND;
         end else begin
            phase_in  = PH_RUN;
            cnt_in    = cnt_next;
            rising_in = rising_cur;
            if (rising_cur) begin
               if (sample > max_ff && cmp.rise_ok) begin
                  max_in  = sample;
                  idx_in  = cnt_next;
                  held_in = 1'b1;
               end else if (sample < prev_ff) begin
                  rising_in = 1'b0;
               end
            end else begin
               if (held_ff) begin
                  if (cmp.fall_ok) begin
                     emit    = 1'b1;
                     held_in = 1'b0;
                     max_in  = '0;
                     min_in  = sample;
                  end
               end else if (sample < min_ff) begin
                  min_in = sample;
               end
               if (sample > prev_ff) begin
                  rising_in = 1'b1;
               end
            end
            prev_in = sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FIRST;
         prev_ff   <= '0;
         min_ff    <= '0;
         max_ff    <= '0;
         idx_ff    <= '0;
         cnt_ff    <= '0;
         held_ff   <= 1'b1;
         rising_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         prev_ff   <= prev_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
         idx_ff    <= idx_in;
         cnt_ff    <= cnt_in;
         held_ff   <= held_in;
         rising_ff <= rising_in;
      end
   end

   a_start_restarts: assert property (@(posedge clock) disable iff (reset)
      valid && start_of_record |=> phase_ff == PH_SECOND && cnt_ff == '0 && held_ff)
      else $error("record start did not restart tracking");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      emit |=> !held_ff && max_ff == '0)
      else $error("candidate still held after a peak");

   a_emit_needs_candidate: assert property (@(posedge clock) disable iff (reset)
      emit |-> held_ff && phase_ff != PH_FIRST)
      else $error("peak reported without a candidate");

   a_index_bounded: assert property (@(posedge clock) disable iff (reset)
      held_ff |-> idx_ff <= cnt_ff)
      else $error("candidate index ahead of sample counter");

endmodule

FILE: dv/tb_relative_depth_peak_detector.sv
// testbench of the relative depth peak detector: random records, predicted peaks, scoreboard
module tb_relative_depth_peak_detector import rdpd_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_W = 16;
   localparam int INDEX_W  = 32;
   localparam longint FRAC_ONE = longint'(1) << FRAC_SHIFT;
   localparam int ITEMS_PER_PHASE = 185;
   localparam int DRAIN_CYCLES = 8;

   typedef enum logic [1:0] {REC_WAIT_FIRST, REC_WAIT_SECOND, REC_RUNNING} record_phase_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       sor;
   } sample_item_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [SAMPLE_W-1:0]  req_sample = '0;
   logic                        req_start_of_record = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic        [INDEX_W-1:0]   rsp_peak_index;
   logic                        csr_write_enable = 1'b0;
   logic        [FRAC_WIDTH-1:0] csr_write_data = '0;

   relative_depth_peak_detector #(
      .SAMPLE_WIDTH(SAMPLE_W),
      .INDEX_WIDTH (INDEX_W)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .req_start_of_record(req_start_of_record),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_peak_index     (rsp_peak_index),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   // pending samples and bookkeeping
   sample_item_type         pending_samples[$];
   logic [INDEX_W-1:0]      peak_index_queue[$];
   int unsigned             queued_count = 0;
   int unsigned             accepted_count = 0;
   int unsigned             peaks_checked = 0;
   int unsigned             records_queued = 0;
   int unsigned             error_count = 0;
   bit                      req_idle_on = 1'b1;
   bit                      rsp_idle_on = 1'b1;
   int unsigned             req_gap_left = 0;
   int unsigned             rsp_hold_left = 0;

   // tracking state of the predictor
   logic        [FRAC_WIDTH-1:0] depth_frac = DEPTH_FRACTION_RESET;
   logic signed [SAMPLE_W-1:0]   prev_sample = '0;
   logic signed [SAMPLE_W-1:0]   run_min = '0;
   logic signed [SAMPLE_W-1:0]   cand_max = '0;
   logic        [INDEX_W-1:0]    cand_idx = '0;
   logic        [INDEX_W-1:0]    sample_count = '0;
   bit                           cand_held = 1'b1;
   bit                           rising_dir = 1'b0;
   record_phase_type             rec_phase = REC_WAIT_FIRST;

   task automatic track_sample(input logic signed [SAMPLE_W-1:0] s, input logic sor);
      logic [INDEX_W-1:0] idx;
      longint sf;
      longint frac;
      sf   = longint'(s);
      frac = longint'(depth_frac);
      if (sor || rec_phase == REC_WAIT_FIRST) begin
         prev_sample  = s;
         run_min      = s;
         cand_max     = s;
         cand_idx     = '0;
         cand_held    = 1'b1;
         rising_dir   = 1'b0;
         sample_count = '0;
         rec_phase    = REC_WAIT_SECOND;
      end else begin
         if (rec_phase == REC_WAIT_SECOND) begin
            rising_dir = s > prev_sample;
            rec_phase  = REC_RUNNING;
         end
         // index saturates at all ones
         idx = (sample_count == '1) ? sample_count : sample_count + 1'b1;
         sample_count = idx;
         if (rising_dir) begin
            if (s > cand_max && sf * frac >= longint'(run_min) * FRAC_ONE) begin
               cand_max  = s;
               cand_idx  = idx;
               cand_held = 1'b1;
            end else if (s < prev_sample) begin
               rising_dir = 1'b0;
            end
         end else begin
            if (cand_held) begin
               if (sf * FRAC_ONE <= longint'(cand_max) * frac) begin
                  peak_index_queue.push_back(cand_idx);
                  cand_held = 1'b0;
                  cand_max  = '0;
                  run_min   = s;
               end
            end else if (s < run_min) begin
               run_min = s;
            end
            if (s > prev_sample) rising_dir = 1'b1;
         end
         prev_sample = s;
      end
   endtask

   task automatic queue_sample(input int v, input logic sor);
      sample_item_type item;
      item.sample = SAMPLE_W'(v);
      item.sor    = sor;
      pending_samples.push_back(item);
      queued_count++;
   endtask

   // one record: triangle wave, full-range noise, extremes or a random walk
   task automatic queue_record(input int len);
      int style, period, base, step, noise, v, pos, tri_v;
      logic sor;
      style  = int'($urandom_range(0, 3));
      period = int'($urandom_range(2, 24));
      base   = int'($urandom_range(0, 40000)) - 20000;
      step   = int'($urandom_range(1, 3000));
      noise  = int'($urandom_range(0, 500));
      v      = base;
      for (int k = 0; k < len; k++) begin
         case (style)
            0: begin
               pos   = k % period;
               tri_v = (pos < period / 2) ? pos : period - pos;
               v     = base + step * tri_v + int'($urandom_range(0, 2 * noise)) - noise;
            end
            1: v = int'($urandom_range(0, 65535)) - 32768;
            2: begin
               case ($urandom_range(0, 3))
                  0:       v = -32768;
                  1:       v = 32767;
                  2:       v = 0;
                  default: v = -1;
               endcase
            end
            default: v = v + int'($urandom_range(0, 2 * step)) - step;
         endcase
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         // mostly well-formed records, now and then a missing or stray start flag
         sor = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 99) == 0);
         queue_sample(v, sor);
      end
      records_queued++;
   endtask

   task automatic wait_for_drain();
      while (accepted_count != queued_count || peak_index_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_depth_fraction(input logic [FRAC_WIDTH-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // sample source
   always @(posedge clock) begin : req_source
      sample_item_type item;
      if (reset) begin
         req_valid    <= 1'b0;
         req_gap_left <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_gap_left != 0) begin
            req_valid    <= 1'b0;
            req_gap_left <= req_gap_left - 1;
         end else if (pending_samples.size() != 0) begin
            item = pending_samples.pop_front();
            req_valid           <= 1'b1;
            req_sample          <= item.sample;
            req_start_of_record <= item.sor;
            req_gap_left <= (req_idle_on && $urandom_range(0, 3) == 0) ?
                            $urandom_range(0, 17) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result sink with random stall
   always @(posedge clock) begin : rsp_sink
      int unsigned hold;
      hold = rsp_hold_left;
      if (rsp_valid && !rsp_stall)
         hold = (rsp_idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
      else if (hold == 0 && rsp_idle_on && $urandom_range(0, 15) == 0)
         hold = $urandom_range(1, 17);
      if (reset) begin
         rsp_stall     <= 1'b0;
         rsp_hold_left <= 0;
      end else begin
         rsp_stall     <= hold != 0;
         rsp_hold_left <= (hold != 0) ? hold - 1 : 0;
      end
   end

   // predict on each sample transfer, check each result transfer
   always @(posedge clock) begin : scoreboard
      logic [INDEX_W-1:0] expected_index;
      if (reset) begin
         depth_frac   = DEPTH_FRACTION_RESET;
         prev_sample  = '0;
         run_min      = '0;
         cand_max     = '0;
         cand_idx     = '0;
         sample_count = '0;
         cand_held    = 1'b1;
         rising_dir   = 1'b0;
         rec_phase    = REC_WAIT_FIRST;
      end else begin
         if (csr_write_enable) depth_frac = csr_write_data;
         if (req_valid && !req_stall) begin
            track_sample(req_sample, req_start_of_record);
            accepted_count++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (peak_index_queue.size() == 0) begin
               error_count++;
               if (error_count <= 20)
                  $display("%0t: unexpected peak_index transfer, expected none, actual %0d",
                           $time, rsp_peak_index);
            end else begin
               expected_index = peak_index_queue.pop_front();
               peaks_checked++;
               if (rsp_peak_index !== expected_index) begin
                  error_count++;
                  if (error_count <= 20)
                     $display("%0t: peak_index mismatch, expected %0d, actual %0d",
                              $time, expected_index, rsp_peak_index);
               end
            end
         end
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      int directed_s[] = '{100, 200, 32767, 1000, -32768, -32768, 0, 32767, 32767,
                           24575, 24575, 5, 5, 6, 4, 1, -1, -32768, 32767, -32768,
                           7, 7, 32767};
      bit directed_sor[] = '{0, 0, 0, 0, 0, 0, 0, 0, 0,
                             0, 0, 1, 0, 0, 1, 1, 0, 0, 0, 0,
                             1, 1, 0};
      logic [FRAC_WIDTH-1:0] frac_plan[$];
      int unsigned phase_start;
      int len;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset fraction, first sample without a start flag
      foreach (directed_s[i]) queue_sample(directed_s[i], directed_sor[i]);
      records_queued += 6;
      wait_for_drain();

      frac_plan = '{DEPTH_FRACTION_RESET, 17'd0, 17'd65536, 17'd131071, 17'd1,
                    17'd32768, 17'd65535,
                    FRAC_WIDTH'($urandom_range(0, 131071)),
                    FRAC_WIDTH'($urandom_range(0, 131071))};
      foreach (frac_plan[p]) begin
         write_depth_fraction(frac_plan[p]);
         req_idle_on = (p % 3) != 0;
         rsp_idle_on = (p % 3) != 1;
         phase_start = queued_count;
         while (queued_count - phase_start < ITEMS_PER_PHASE) begin
            len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 3))
                                              : int'($urandom_range(4, 48));
            queue_record(len);
         end
         // sender holds off here until every peak has come back
         wait_for_drain();
      end

      if (peak_index_queue.size() != 0) begin
         error_count++;
         $display("%0t: %0d peak_index results never arrived, expected %0d first",
                  $time, peak_index_queue.size(), peak_index_queue[0]);
      end
      $display("covered %0d samples in about %0d records over %0d depth fraction settings",
               accepted_count, records_queued, frac_plan.size() + 1);
      $display("checked %0d peak indices, %0d errors", peaks_checked, error_count);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
